>>> src/minimum_window_cover_assert.svh
// Assertion macros for the minimum window cover block.
// Used by minimum_window_cover.sv; expects clk_i and rst_ni in scope.
`ifndef MINIMUM_WINDOW_COVER_ASSERT_SVH
`define MINIMUM_WINDOW_COVER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MWC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define MWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mwc_pkg.sv
// Shared types and constants for the minimum window cover block.
// No dependencies; imported by every module of the block except mwc_ram.
package mwc_pkg;

  localparam int CHAR_W      = 7;
  localparam int ACT_W       = 2;
  localparam int PLEN_W      = 16;
  localparam int NEED_W      = 17;
  localparam int OUT_START_W = 16;
  localparam int OUT_LEN_W   = 13;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 32;

  localparam logic [PLEN_W-1:0] PLEN_LIMIT = '1;

  typedef logic signed [NEED_W-1:0] need_t;

  localparam need_t NEED_ZERO = need_t'(0);
  localparam need_t NEED_ONE  = need_t'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_WR,
    ST_TXT_WR,
    ST_CHK,
    ST_WIN_RD,
    ST_NEED_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } need_cmd_t;

endpackage

>>> src/mwc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mwc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mwc_need.sv
// Per-character need count table: a RAM plus one valid bit per entry.
// Depends on mwc_pkg and mwc_ram; an entry never written since clear reads zero.
module mwc_need import mwc_pkg::*; #(
  parameter int  ALPHABET = 128,
  localparam int NAW      = $clog2(ALPHABET)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  need_cmd_t      cmd_i,
  input  logic [NAW-1:0] raddr_i,
  input  logic [NAW-1:0] waddr_i,
  input  need_t          wdata_i,
  output need_t          rdata_o
);

  logic [ALPHABET-1:0] vld_q;
  logic                rd_vld_q;
  logic [NEED_W-1:0]   ram_rdata;

  mwc_ram #(
    .WIDTH (NEED_W),
    .DEPTH (ALPHABET)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        vld_q <= '0;
      end else if (cmd_i.wr) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? need_t'(ram_rdata) : NEED_ZERO;

endmodule

>>> src/minimum_window_cover.sv
// Minimum window cover top level: control sequencer, window buffer, result register.
// Depends on mwc_pkg, mwc_ram, mwc_need and minimum_window_cover_assert.svh.
//
//  port group  | dir | tdata                                   | tuser
//  s_axis      | in  | ch[6:0], zero[7]                        | action[1:0]
//  m_axis      | out | found, best_start, best_length, overflow| -
//
// Steps per request: clear, ignored, overflow or text with an empty pattern go straight to the result;
// a pattern character adds a need count write; a text character adds write and check steps, plus a
// read and a write step for every character dropped from the left, set by the need count RAM round trip.
// Reset leaves the block idle with all counts zero; no clearing pass is run.
// Input is taken while a previous result waits; a stalled output holds the
// sequencer in its final step until the result register frees.
`include "minimum_window_cover_assert.svh"

module minimum_window_cover import mwc_pkg::*; #(
  parameter int WINDOW_MAX = 4096,
  parameter int TEXT_MAX   = 65536,
  parameter int ALPHABET   = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // ch[6:0], zero fill[7]
  input  logic [ACT_W-1:0]      s_axis_tuser_i,   // action[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // found[0], best_start[16:1], best_length[29:17], overflow[30], zero fill[31]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int NAW = $clog2(ALPHABET);
  localparam int WAW = $clog2(WINDOW_MAX);
  localparam int PW  = $clog2(TEXT_MAX + 1);
  localparam int LW  = $clog2(WINDOW_MAX + 1);
  localparam logic [PW-1:0]  TextMaxP = PW'(TEXT_MAX);
  localparam logic [WAW-1:0] WinLast  = WAW'(WINDOW_MAX - 1);

  state_e                  state_q, state_d;
  logic [PLEN_W-1:0]       plen_q, plen_d;
  logic [PLEN_W-1:0]       matched_q, matched_d;
  logic [PW-1:0]           left_q, left_d;
  logic [PW-1:0]           right_q, right_d;
  logic [WAW-1:0]          wptr_q, wptr_d;
  logic [WAW-1:0]          lptr_q, lptr_d;
  logic [LW-1:0]           best_len_q, best_len_d;
  logic [PW-1:0]           best_start_q, best_start_d;
  logic                    ovf_q, ovf_d;
  logic [NAW-1:0]          chr_q, chr_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;

  need_cmd_t               need_cmd;
  logic [NAW-1:0]          need_raddr;
  need_t                   need_wdata;
  need_t                   need_rdata;
  need_t                   need_sum;
  logic                    win_we;
  logic                    win_re;
  logic [CHAR_W-1:0]       win_rdata;

  logic                    in_fire;
  action_e                 in_action;
  logic [CHAR_W-1:0]       in_ch;
  logic                    ch_ok;
  logic [PW-1:0]           diff;
  logic [LW-1:0]           cur_len;
  logic                    win_full;
  logic [WAW-1:0]          wptr_inc;
  logic [WAW-1:0]          lptr_inc;
  logic                    clr_fire;
  logic                    best_nz;
  logic                    best_hold;

  assign in_action = action_e'(s_axis_tuser_i);
  assign in_ch     = s_axis_tdata_i[CHAR_W-1:0];
  assign ch_ok     = 32'(in_ch) < 32'(ALPHABET);
  assign diff      = right_q - left_q;
  assign cur_len   = LW'(diff);
  assign win_full  = 32'(diff) >= 32'(WINDOW_MAX);
  assign wptr_inc  = (wptr_q == WinLast) ? '0 : wptr_q + WAW'(1);
  assign lptr_inc  = (lptr_q == WinLast) ? '0 : lptr_q + WAW'(1);
  assign need_sum  = need_rdata + NEED_ONE;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign clr_fire  = in_fire && (in_action == ACT_CLEAR);
  assign best_nz   = best_len_q != '0;
  assign best_hold = best_nz && !clr_fire;

  mwc_need #(
    .ALPHABET (ALPHABET)
  ) u_need (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (need_cmd),
    .raddr_i (need_raddr),
    .waddr_i (chr_q),
    .wdata_i (need_wdata),
    .rdata_o (need_rdata)
  );

  mwc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wptr_q),
    .wdata_i (in_ch),
    .re_i    (win_re),
    .raddr_i (lptr_q),
    .rdata_o (win_rdata)
  );

  always_comb begin
    state_d      = state_q;
    plen_d       = plen_q;
    matched_d    = matched_q;
    left_d       = left_q;
    right_d      = right_q;
    wptr_d       = wptr_q;
    lptr_d       = lptr_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    ovf_d        = ovf_q;
    chr_d        = chr_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    need_cmd     = '0;
    need_raddr   = NAW'(in_ch);
    need_wdata   = need_sum;
    win_we       = 1'b0;
    win_re       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DONE;
          chr_d   = NAW'(in_ch);
          case (in_action)
            ACT_CLEAR: begin
              need_cmd.clear = 1'b1;
              plen_d         = '0;
              matched_d      = '0;
              left_d         = '0;
              right_d        = '0;
              wptr_d         = '0;
              lptr_d         = '0;
              best_len_d     = '0;
              best_start_d   = '0;
              ovf_d          = 1'b0;
            end
            ACT_PATTERN: begin
              if (!ovf_q && ch_ok && right_q == '0) begin
                if (plen_q == PLEN_LIMIT) begin
                  ovf_d = 1'b1;
                end else begin
                  need_cmd.rd = 1'b1;
                  state_d     = ST_PAT_WR;
                end
              end
            end
            ACT_TEXT: begin
              if (!ovf_q && ch_ok) begin
                if (right_q >= TextMaxP || win_full) begin
                  ovf_d = 1'b1;
                end else if (plen_q == '0) begin
                  right_d = right_q + PW'(1);
                  left_d  = right_q + PW'(1);
                  wptr_d  = wptr_inc;
                  lptr_d  = wptr_inc;
                end else begin
                  win_we      = 1'b1;
                  need_cmd.rd = 1'b1;
                  state_d     = ST_TXT_WR;
                end
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_PAT_WR: begin
        need_cmd.wr = 1'b1;
        plen_d      = plen_q + PLEN_W'(1);
        state_d     = ST_DONE;
      end
      ST_TXT_WR: begin
        need_cmd.wr = 1'b1;
        need_wdata  = need_rdata - NEED_ONE;
        if (need_rdata > NEED_ZERO) begin
          matched_d = matched_q + PLEN_W'(1);
        end
        right_d = right_q + PW'(1);
        wptr_d  = wptr_inc;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (matched_q == plen_q && left_q < right_q) begin
          if (best_len_q == '0 || cur_len < best_len_q) begin
            best_len_d   = cur_len;
            best_start_d = left_q;
          end
          win_re  = 1'b1;
          state_d = ST_WIN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WIN_RD: begin
        need_cmd.rd = 1'b1;
        need_raddr  = NAW'(win_rdata);
        chr_d       = NAW'(win_rdata);
        state_d     = ST_NEED_WR;
      end
      ST_NEED_WR: begin
        need_cmd.wr = 1'b1;
        if (need_sum > NEED_ZERO) begin
          matched_d = matched_q - PLEN_W'(1);
        end
        left_d  = left_q + PW'(1);
        lptr_d  = lptr_inc;
        state_d = ST_CHK;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, ovf_q, OUT_LEN_W'(best_len_q),
                         OUT_START_W'(best_start_q), best_len_q != '0};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      plen_q       <= '0;
      matched_q    <= '0;
      left_q       <= '0;
      right_q      <= '0;
      wptr_q       <= '0;
      lptr_q       <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      plen_q       <= plen_d;
      matched_q    <= matched_d;
      left_q       <= left_d;
      right_q      <= right_d;
      wptr_q       <= wptr_d;
      lptr_q       <= lptr_d;
      best_len_q   <= best_len_d;
      best_start_q <= best_start_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q      <= chr_d;
    out_data_q <= out_data_d;
  end

  `MWC_ASSERT_ALWAYS(a_matched_le_plen, matched_q <= plen_q, "matched exceeds pattern length")
  `MWC_ASSERT_ALWAYS(a_left_le_right, left_q <= right_q, "left position passed right position")
  `MWC_ASSERT_NEXT(a_ovf_sticky, ovf_q && !clr_fire, ovf_q, "overflow dropped without clear")
  `MWC_ASSERT_NEXT(a_best_shrinks, best_hold, best_nz && best_len_q <= $past(best_len_q), "best grew")

endmodule

>>> dv/minimum_window_cover_check.sv
// Checker for minimum_window_cover: watches both stream channels, predicts each result
// from the requests it sees and compares field by field. Depends on mwc_pkg.
module minimum_window_cover_check import mwc_pkg::*; #(
  parameter int WINDOW_MAX = 4096,
  parameter int TEXT_MAX   = 65536,
  parameter int ALPHABET   = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [ACT_W-1:0]      s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    fail_count_o,
  output int                    due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                   found;
    logic [OUT_START_W-1:0] start;
    logic [OUT_LEN_W-1:0]   length;
    logic                   ovf;
  } cover_t;

  cover_t due_covers[$];

  int          need_cnt[ALPHABET];
  logic [CHAR_W-1:0] win_buf[WINDOW_MAX];
  int unsigned pat_len;
  int unsigned hits;
  int unsigned left_pos;
  int unsigned right_pos;
  int unsigned best_len;
  int unsigned best_start;
  logic        ovf;
  int          fails = 0;
  int          due = 0;

  assign fail_count_o = fails;
  assign due_count_o  = due;

  function void clear_state();
    foreach (need_cnt[i]) need_cnt[i] = 0;
    pat_len    = 0;
    hits       = 0;
    left_pos   = 0;
    right_pos  = 0;
    best_len   = 0;
    best_start = 0;
    ovf        = 1'b0;
  endfunction

  function void add_pattern_char(int unsigned c);
    if (right_pos != 0) return;
    if (pat_len >= PLEN_LIMIT) begin
      ovf = 1'b1;
      return;
    end
    need_cnt[c]++;
    pat_len++;
  endfunction

  function void take_text_char(int unsigned c);
    int unsigned gone;
    if (right_pos >= TEXT_MAX || right_pos - left_pos >= WINDOW_MAX) begin
      ovf = 1'b1;
      return;
    end
    if (pat_len == 0) begin
      right_pos++;
      left_pos = right_pos;
      return;
    end
    win_buf[right_pos % WINDOW_MAX] = CHAR_W'(c);
    if (need_cnt[c] > 0) hits++;
    need_cnt[c]--;
    right_pos++;
    // shrink from the left while the window still covers the pattern
    while (hits == pat_len && left_pos < right_pos) begin
      if (best_len == 0 || right_pos - left_pos < best_len) begin
        best_len   = right_pos - left_pos;
        best_start = left_pos;
      end
      gone = win_buf[left_pos % WINDOW_MAX];
      need_cnt[gone]++;
      if (need_cnt[gone] > 0) hits--;
      left_pos++;
    end
  endfunction

  function cover_t predict_cover(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] c);
    cover_t r;
    if (act == ACT_CLEAR) begin
      clear_state();
    end else if (!ovf && c < ALPHABET) begin
      if (act == ACT_PATTERN) add_pattern_char(c);
      else if (act == ACT_TEXT) take_text_char(c);
    end
    r.found  = (best_len != 0);
    r.start  = best_start[OUT_START_W-1:0];
    r.length = best_len[OUT_LEN_W-1:0];
    r.ovf    = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cover_t got;
    cover_t want;
    if (!rst_ni) begin
      clear_state();
      due_covers.delete();
      due <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.found  = m_tdata_i[0];
        got.start  = m_tdata_i[OUT_START_W:1];
        got.length = m_tdata_i[OUT_START_W+OUT_LEN_W:OUT_START_W+1];
        got.ovf    = m_tdata_i[OUT_START_W+OUT_LEN_W+1];
        if (due_covers.size() == 0) begin
          $error("result with none expected: tdata %h", m_tdata_i);
          fails++;
        end else begin
          want = due_covers.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            fails++;
          end
          if (got.start !== want.start) begin
            $error("best_start: expected %0d, actual %0d", want.start, got.start);
            fails++;
          end
          if (got.length !== want.length) begin
            $error("best_length: expected %0d, actual %0d", want.length, got.length);
            fails++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow: expected %0d, actual %0d", want.ovf, got.ovf);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        due_covers.push_back(predict_cover(s_tuser_i, s_tdata_i[CHAR_W-1:0]));
      end
      due <= due_covers.size();
    end
  end

endmodule

>>> dv/minimum_window_cover_test.sv
// Top of the minimum_window_cover testbench: clock, reset, request stimulus and verdict.
// Depends on mwc_pkg, minimum_window_cover and minimum_window_cover_check.
module minimum_window_cover_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mwc_pkg::*;

  localparam int WIN         = 4096;
  localparam int TXT         = 65536;
  localparam int ABC         = 128;
  localparam int IDLE_LIMIT  = 60000;
  localparam int DRAIN       = 32;
  localparam int ITEM_TARGET = 1350;
  localparam int SEND_IDLE[4]  = '{0, 45, 0, 27};
  localparam int RECV_STALL[4] = '{0, 0, 45, 27};
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_B = 7'h62;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // ch[6:0], zero fill[7]
  logic [ACT_W-1:0]      s_tuser = '0;   // action[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // found, best_start, best_length, overflow
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    fail_count;
  int                    due_count;
  int                    quiet_cycles = 0;
  int                    sent_items = 0;

  minimum_window_cover #(
    .WINDOW_MAX(WIN),
    .TEXT_MAX  (TXT),
    .ALPHABET  (ABC)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  minimum_window_cover_check #(
    .WINDOW_MAX(WIN),
    .TEXT_MAX  (TXT),
    .ALPHABET  (ABC)
  ) cover_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL minimum_window_cover");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, c};
    do @(posedge clk_i); while (!s_tready);
    if (act != ACT_UNUSED) sent_items++;
  endtask

  // hold off until every outstanding result has been taken
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
  endtask

  task automatic run_episode();
    logic [CHAR_W-1:0] letters[4];
    int n_let;
    int pick;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) send_request(ACT_W'($urandom_range(3)), CHAR_W'($urandom));
      return;
    end
    foreach (letters[i]) letters[i] = CHAR_W'($urandom);
    n_let = $urandom_range(2, 4);
    if ($urandom_range(4) != 0) send_request(ACT_CLEAR, CHAR_W'($urandom));
    repeat ($urandom_range(1, 5)) send_request(ACT_PATTERN, letters[$urandom_range(n_let - 1)]);
    repeat ($urandom_range(3, 30)) begin
      pick = $urandom_range(19);
      if (pick == 0) send_request(ACT_UNUSED, CHAR_W'($urandom));
      else if (pick == 1) send_request(ACT_PATTERN, letters[$urandom_range(n_let - 1)]);
      else if (pick == 2) send_request(ACT_TEXT, CHAR_W'($urandom));
      else send_request(ACT_TEXT, letters[$urandom_range(n_let - 1)]);
    end
  endtask

  initial begin : main
    int goal;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern, pattern after text, unused action
    send_request(ACT_CLEAR, 7'h00);
    send_request(ACT_TEXT, 7'h41);
    send_request(ACT_PATTERN, 7'h41);
    send_request(ACT_UNUSED, 7'h7F);
    send_request(ACT_CLEAR, 7'h7F);
    send_request(ACT_PATTERN, 7'h00);
    send_request(ACT_PATTERN, 7'h7F);
    send_request(ACT_PATTERN, 7'h00);
    send_request(ACT_TEXT, 7'h7F);
    send_request(ACT_TEXT, 7'h00);
    send_request(ACT_UNUSED, 7'h55);
    send_request(ACT_TEXT, 7'h2A);
    send_request(ACT_TEXT, 7'h00);
    send_request(ACT_TEXT, 7'h7F);
    send_request(ACT_TEXT, 7'h00);
    settle();

    // keep the earliest of equal windows, then take a shorter one
    send_request(ACT_CLEAR, 7'h00);
    send_request(ACT_PATTERN, CH_A);
    send_request(ACT_PATTERN, CH_A);
    send_request(ACT_TEXT, CH_A);
    send_request(ACT_TEXT, CH_B);
    send_request(ACT_TEXT, CH_B);
    send_request(ACT_TEXT, CH_A);
    send_request(ACT_TEXT, CH_B);
    send_request(ACT_TEXT, CH_B);
    send_request(ACT_TEXT, CH_A);
    send_request(ACT_TEXT, CH_A);
    send_request(ACT_PATTERN, CH_B);
    send_request(ACT_CLEAR, 7'h00);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  <= SEND_IDLE[ph];
      recv_stall_pct <= RECV_STALL[ph];
      goal = sent_items + ITEM_TARGET / 4;
      while (sent_items < goal) begin
        run_episode();
        if ($urandom_range(24) == 0) settle();
      end
      settle();
    end

    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS minimum_window_cover");
    end else begin
      $display("FAIL minimum_window_cover");
    end
    $finish;
  end

endmodule
